FILE: hdl/urif_pkg.sv
// urif_pkg: shared types and constants for the four-port uart receive ring buffer
// depends on nothing; imported by uart_rx_interrupt_fifo_core
package urif_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int PORT_COUNT   = 4;
    localparam int PORT_W       = 2;
    localparam int INDEX_W      = $clog2(BUFFER_DEPTH);
    localparam int COUNT_W      = INDEX_W + 1;
    localparam int STORE_DEPTH  = PORT_COUNT * BUFFER_DEPTH;
    localparam int ADDR_W       = PORT_W + INDEX_W;

    typedef logic [PORT_W-1:0]  t_port;
    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [8:0]         t_status;

    localparam t_count SIZE_MAX = COUNT_W'(BUFFER_DEPTH);
    localparam t_count SIZE_MIN = COUNT_W'(1);

    // interrupt identification codes
    localparam logic [2:0] ID_LINE_STATUS = 3'd3;
    localparam logic [2:0] ID_DATA_AVAIL  = 3'd2;
    localparam logic [2:0] ID_TIMEOUT     = 3'd6;

    // command codes
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [7:0] LS_DATA_READY = 8'h01;
    localparam logic [7:0] LS_ERRORS     = 8'h9E;
    localparam t_status    TIMEOUT_BIT   = 9'h100;

endpackage

FILE: hdl/uart_rx_interrupt_fifo_core.sv
// uart_rx_interrupt_fifo_core: four-port receive ring buffer fed by uart interrupt events
// depends on urif_pkg and urif_ram
//
// One item (an interrupt event or a byte read) is taken in every cycle; busy never rises.
// Its result appears on the o_ ports, marked by o_done, in the cycle after the
// accepting edge; the result is registered, as is the read port of the byte ram, and
// the port flags, indices and counts are updated at the accepting edge, so the next
// item sees them at once. Results cannot be stalled and must be taken as they come.
// Size registers are written through i_cfg_*, always ready; a write clamps the size to
// 1..64 and empties that port's ring while keeping its latched line status. The byte
// ram is not cleared at reset and needs no clearing pass.
module uart_rx_interrupt_fifo_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_command,
    input  urif_pkg::t_port     i_port,
    input  logic [2:0]          i_int_id,
    input  logic [7:0]          i_line_status,
    input  logic [7:0]          i_rx_byte,
    output logic                o_done,
    output logic [7:0]          o_read_byte,
    output urif_pkg::t_status   o_lsr_latch,
    output logic                o_overflow,
    output logic                o_full_res,
    output logic                o_not_empty,
    output urif_pkg::t_count    o_fill_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  urif_pkg::t_port     i_cfg_index,
    input  urif_pkg::t_count    i_cfg_data
);
    import urif_pkg::*;

    // per-port state
    t_count  r_size     [PORT_COUNT];
    t_index  r_wr_idx   [PORT_COUNT];
    t_index  r_rd_idx   [PORT_COUNT];
    t_count  r_held     [PORT_COUNT];
    logic    r_ovf      [PORT_COUNT];
    logic    r_full     [PORT_COUNT];
    logic    r_nonempty [PORT_COUNT];
    t_status r_latch    [PORT_COUNT];

    // result register
    logic    r_done;
    logic    r_pop_hit;
    t_status r_status;
    logic    r_res_ovf;
    logic    r_res_full;
    logic    r_res_nonempty;
    t_count  r_res_fill;

    // next values for the selected port
    t_index  n_wr_idx;
    t_index  n_rd_idx;
    t_count  n_held;
    logic    n_ovf;
    logic    n_full;
    logic    n_nonempty;
    t_status n_latch;
    logic    n_pop_hit;

    logic       accept;
    logic       do_push;
    logic [7:0] push_byte;
    logic       ram_we;
    t_count     wr_inc;
    t_count     rd_inc;
    t_count     cfg_size;
    logic [7:0] ram_q;

    assign accept      = i_start && !o_busy;
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_wr_idx   = r_wr_idx[i_port];
        n_rd_idx   = r_rd_idx[i_port];
        n_held     = r_held[i_port];
        n_ovf      = r_ovf[i_port];
        n_full     = r_full[i_port];
        n_nonempty = r_nonempty[i_port];
        n_latch    = r_latch[i_port];
        n_pop_hit  = 1'b0;
        push_byte  = 8'd0;
        ram_we     = 1'b0;
        wr_inc     = {1'b0, r_wr_idx[i_port]} + COUNT_W'(1);
        rd_inc     = {1'b0, r_rd_idx[i_port]} + COUNT_W'(1);

        if (i_command == CMD_READ) begin
            if (r_held[i_port] == r_size[i_port]) begin
                n_full = 1'b0;
            end
            if (r_held[i_port] != '0) begin
                n_pop_hit = 1'b1;
                n_held    = r_held[i_port] - COUNT_W'(1);
                n_rd_idx  = (rd_inc >= r_size[i_port]) ? '0 : rd_inc[INDEX_W-1:0];
            end else begin
                n_nonempty = 1'b0;
                n_rd_idx   = (r_rd_idx[i_port] >= r_size[i_port][INDEX_W-1:0]
                              && r_size[i_port] != SIZE_MAX) ? '0 : r_rd_idx[i_port];
            end
        end else begin
            case (i_int_id)
                ID_LINE_STATUS: begin
                    if ((i_line_status & LS_ERRORS) != 8'd0) begin
                        n_latch = {1'b0, i_line_status};
                    end else if ((i_line_status & LS_DATA_READY) != 8'd0) begin
                        push_byte = i_rx_byte;
                    end
                end
                ID_DATA_AVAIL: begin
                    push_byte = i_rx_byte;
                end
                ID_TIMEOUT: begin
                    n_latch = r_latch[i_port] | TIMEOUT_BIT;
                end
                default: begin
                end
            endcase
        end

        // zero bytes are never stored
        do_push = (i_command == CMD_EVENT) && (push_byte != 8'd0);
        if (do_push) begin
            if (r_held[i_port] == r_size[i_port]) begin
                n_ovf = 1'b1;
                n_full = 1'b1;
            end else begin
                ram_we   = 1'b1;
                n_held   = r_held[i_port] + COUNT_W'(1);
                n_wr_idx = (wr_inc >= r_size[i_port]) ? '0 : wr_inc[INDEX_W-1:0];
                if (n_held == r_size[i_port]) begin
                    n_full = 1'b1;
                end
            end
            n_nonempty = 1'b1;
        end
    end

    // clamp a written size into 1..BUFFER_DEPTH
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_size = SIZE_MIN;
        end else if (i_cfg_data > SIZE_MAX) begin
            cfg_size = SIZE_MAX;
        end else begin
            cfg_size = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORT_COUNT; p++) begin
                r_size[p]     <= SIZE_MAX;
                r_wr_idx[p]   <= '0;
                r_rd_idx[p]   <= '0;
                r_held[p]     <= '0;
                r_ovf[p]      <= 1'b0;
                r_full[p]     <= 1'b0;
                r_nonempty[p] <= 1'b0;
                r_latch[p]    <= '0;
            end
            r_done <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_wr_idx[i_port]   <= n_wr_idx;
                r_rd_idx[i_port]   <= n_rd_idx;
                r_held[i_port]     <= n_held;
                r_ovf[i_port]      <= n_ovf;
                r_full[i_port]     <= n_full;
                r_nonempty[i_port] <= n_nonempty;
                r_latch[i_port]    <= n_latch;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_size[i_cfg_index]     <= cfg_size;
                r_wr_idx[i_cfg_index]   <= '0;
                r_rd_idx[i_cfg_index]   <= '0;
                r_held[i_cfg_index]     <= '0;
                r_ovf[i_cfg_index]      <= 1'b0;
                r_full[i_cfg_index]     <= 1'b0;
                r_nonempty[i_cfg_index] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_hit      <= accept && n_pop_hit;
        r_status       <= n_latch;
        r_res_ovf      <= n_ovf;
        r_res_full     <= n_full;
        r_res_nonempty <= n_nonempty;
        r_res_fill     <= n_held;
    end

    urif_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && ram_we),
        .i_waddr ({i_port, r_wr_idx[i_port]}),
        .i_wdata (push_byte),
        .i_raddr ({i_port, r_rd_idx[i_port]}),
        .o_rdata (ram_q)
    );

    assign o_done       = r_done;
    assign o_read_byte  = r_pop_hit ? ram_q : 8'd0;
    assign o_lsr_latch  = r_status;
    assign o_overflow   = r_res_ovf;
    assign o_full_res   = r_res_full;
    assign o_not_empty  = r_res_nonempty;
    assign o_fill_count = r_res_fill;

endmodule

FILE: hdl/urif_ram.sv
// urif_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module urif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
